// File: sv/fwrbv_pkg.sv
// Shared constants and types of the FIFO with remove-by-value.
`default_nettype none

package fwrbv_pkg;

    localparam int DEPTH      = 128;
    localparam int VALUE_BITS = 16;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    localparam int KIND_W = 2;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 8;
    localparam int CAP_W  = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    typedef logic [AW-1:0]         t_addr;
    typedef logic [AW:0]           t_sum;
    typedef logic [CW-1:0]         t_cnt;
    typedef logic [CMPW-1:0]       t_cmp;
    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [VAL_W-1:0]      t_port_val;
    typedef logic [CNT_W-1:0]      t_port_cnt;
    typedef logic [CAP_W-1:0]      t_cap;
    typedef logic [KIND_W-1:0]     t_port_kind;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

endpackage

`default_nettype wire

// File: sv/fwrbv_ifs.sv
// Command, result and configuration channel interfaces.
`default_nettype none

interface fwrbv_cmd_if;
    logic                    valid;
    logic                    ready;
    fwrbv_pkg::t_port_kind   kind;
    fwrbv_pkg::t_port_val    value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface fwrbv_res_if;
    logic                    valid;
    logic                    ready;
    logic                    found;
    fwrbv_pkg::t_port_val    out_value;
    logic                    overflow;
    fwrbv_pkg::t_port_cnt    count;
    logic                    is_full;
    logic                    is_empty;
    logic                    head_valid;
    fwrbv_pkg::t_port_val    head_value;

    modport source (output valid, output found, output out_value, output overflow,
                    output count, output is_full, output is_empty, output head_valid,
                    output head_value, input ready);
    modport sink   (input valid, input found, input out_value, input overflow,
                    input count, input is_full, input is_empty, input head_valid,
                    input head_value, output ready);
endinterface

interface fwrbv_cfg_if;
    logic                    valid;
    logic                    ready;
    fwrbv_pkg::t_cap         data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/fifo_with_remove_by_value.sv
// Top level: bounded FIFO of identifiers with push, pop and remove-by-value.
//
// Channels: i_cmd carries one command word (kind, value); o_res returns one
// result word per command; i_cfg writes the capacity register (reset 128),
// always ready, meant to be written while no command is in flight.
// Entries live in one circular buffer memory with a registered read port,
// addressed from a head pointer; the occupancy count is a register.
// Push, no-op and any command on an empty queue go from execution straight
// to the head read and the result. Pop and a remove that matches at the head
// advance the head pointer. A remove that matches at position p > 0 of n
// entries searches p + 1 entries and then closes the gap; a miss searches
// all n entries. The search and the gap-closing copy walk the memory port
// one entry per cycle.
// A result waits in the output register while the receiver stalls; the next
// command is still accepted and runs until its own result is ready.
// Reset empties the queue and restores the capacity; memory contents are not
// cleared, as no entry is read before it is written.
`default_nettype none

module fifo_with_remove_by_value (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fwrbv_cmd_if.sink    i_cmd,
    fwrbv_res_if.source  o_res,
    fwrbv_cfg_if.sink    i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_SHIFT,
        S_HEAD_RD,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic                 valid;
        logic                 found;
        fwrbv_pkg::t_port_val out_value;
        logic                 overflow;
        fwrbv_pkg::t_port_cnt count;
        logic                 is_full;
        logic                 is_empty;
        logic                 head_valid;
        fwrbv_pkg::t_port_val head_value;
    } t_res;

    function automatic fwrbv_pkg::t_addr phys(input fwrbv_pkg::t_addr head,
                                              input fwrbv_pkg::t_cnt  idx);
        fwrbv_pkg::t_sum s;
        s = fwrbv_pkg::t_sum'(head) + fwrbv_pkg::t_sum'(idx);
        if (s >= fwrbv_pkg::t_sum'(fwrbv_pkg::DEPTH)) begin
            s = s - fwrbv_pkg::t_sum'(fwrbv_pkg::DEPTH);
        end
        return s[fwrbv_pkg::AW-1:0];
    endfunction

    t_state             r_state;
    fwrbv_pkg::t_kind   r_kind;
    fwrbv_pkg::t_val    r_val;
    fwrbv_pkg::t_addr   r_head;
    fwrbv_pkg::t_cnt    r_cnt;
    fwrbv_pkg::t_cap    r_cap;
    fwrbv_pkg::t_cnt    r_iss;
    logic               r_rd_valid;
    fwrbv_pkg::t_cnt    r_rd_idx;
    fwrbv_pkg::t_val    r_rdata;
    logic               r_found;
    fwrbv_pkg::t_val    r_outv;
    logic               r_ovf;
    t_res               r_o;

    fwrbv_pkg::t_val    r_slots [fwrbv_pkg::DEPTH];

    logic               accept_in;
    logic               full_now;
    logic               hit;
    logic               last_rd;
    logic               rd_en;
    fwrbv_pkg::t_addr   rd_addr;
    logic               wr_en;
    fwrbv_pkg::t_addr   wr_addr;
    fwrbv_pkg::t_val    wr_data;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign accept_in   = i_cmd.valid && i_cmd.ready;

    assign o_res.valid      = r_o.valid;
    assign o_res.found      = r_o.found;
    assign o_res.out_value  = r_o.out_value;
    assign o_res.overflow   = r_o.overflow;
    assign o_res.count      = r_o.count;
    assign o_res.is_full    = r_o.is_full;
    assign o_res.is_empty   = r_o.is_empty;
    assign o_res.head_valid = r_o.head_valid;
    assign o_res.head_value = r_o.head_value;

    assign full_now = (fwrbv_pkg::t_cmp'(r_cnt) >= fwrbv_pkg::t_cmp'(r_cap))
                   || (r_cnt >= fwrbv_pkg::t_cnt'(fwrbv_pkg::DEPTH));
    assign hit      = r_rd_valid && ((r_kind == fwrbv_pkg::KIND_POP) || (r_rdata == r_val));
    assign last_rd  = r_rd_valid && (r_rd_idx == (r_cnt - fwrbv_pkg::t_cnt'(1)));

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = phys(r_head, r_iss);
        wr_en   = 1'b0;
        wr_addr = phys(r_head, r_cnt);
        wr_data = r_val;
        unique case (r_state)
            S_EXEC: begin
                wr_en = (r_kind == fwrbv_pkg::KIND_PUSH) && !full_now;
            end
            S_SEARCH: begin
                rd_en = (r_iss < r_cnt) && !hit;
            end
            S_SHIFT: begin
                rd_en   = (r_iss < r_cnt);
                wr_en   = r_rd_valid;
                wr_addr = phys(r_head, r_rd_idx - fwrbv_pkg::t_cnt'(1));
                wr_data = r_rdata;
            end
            S_HEAD_RD: begin
                rd_en   = (r_cnt != '0);
                rd_addr = r_head;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slots[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_slots[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_cnt      <= '0;
            r_cap      <= fwrbv_pkg::CAP_RESET;
            r_rd_valid <= 1'b0;
            r_o.valid  <= 1'b0;
        end else begin
            r_rd_valid <= rd_en;
            if (rd_en) begin
                r_rd_idx <= r_iss;
            end
            if (i_cfg.valid) begin
                r_cap <= i_cfg.data;
            end
            if (r_o.valid && o_res.ready) begin
                r_o.valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept_in) begin
                        r_kind  <= fwrbv_pkg::t_kind'(i_cmd.kind);
                        r_val   <= fwrbv_pkg::t_val'(i_cmd.value);
                        r_found <= 1'b0;
                        r_outv  <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_kind)
                        fwrbv_pkg::KIND_PUSH: begin
                            if (full_now) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_cnt <= r_cnt + fwrbv_pkg::t_cnt'(1);
                            end
                            r_state <= S_HEAD_RD;
                        end
                        fwrbv_pkg::KIND_POP, fwrbv_pkg::KIND_REMOVE: begin
                            if (r_cnt == '0) begin
                                r_state <= S_HEAD_RD;
                            end else begin
                                r_iss   <= '0;
                                r_state <= S_SEARCH;
                            end
                        end
                        fwrbv_pkg::KIND_NOP: begin
                            r_state <= S_HEAD_RD;
                        end
                    endcase
                end
                S_SEARCH: begin
                    if (rd_en) begin
                        r_iss <= r_iss + fwrbv_pkg::t_cnt'(1);
                    end
                    if (hit) begin
                        r_found <= 1'b1;
                        r_outv  <= r_rdata;
                        if (r_rd_idx == '0) begin
                            r_head  <= phys(r_head, fwrbv_pkg::t_cnt'(1));
                            r_cnt   <= r_cnt - fwrbv_pkg::t_cnt'(1);
                            r_state <= S_HEAD_RD;
                        end else begin
                            r_iss   <= r_rd_idx + fwrbv_pkg::t_cnt'(1);
                            r_state <= S_SHIFT;
                        end
                    end else if (last_rd) begin
                        r_state <= S_HEAD_RD;
                    end
                end
                S_SHIFT: begin
                    if (r_iss < r_cnt) begin
                        r_iss <= r_iss + fwrbv_pkg::t_cnt'(1);
                    end else begin
                        r_cnt   <= r_cnt - fwrbv_pkg::t_cnt'(1);
                        r_state <= S_HEAD_RD;
                    end
                end
                S_HEAD_RD: begin
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_o.valid || o_res.ready) begin
                        r_o.valid      <= 1'b1;
                        r_o.found      <= r_found;
                        r_o.out_value  <= fwrbv_pkg::t_port_val'(r_outv);
                        r_o.overflow   <= r_ovf;
                        r_o.count      <= fwrbv_pkg::t_port_cnt'(r_cnt);
                        r_o.is_full    <= full_now;
                        r_o.is_empty   <= (r_cnt == '0);
                        r_o.head_valid <= (r_cnt != '0);
                        r_o.head_value <= (r_cnt != '0) ? fwrbv_pkg::t_port_val'(r_rdata)
                                                        : '0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/fwrbv_chk.sv
// Port-level checker for the FIFO with remove-by-value, bound to the top level.
`default_nettype none

module fwrbv_chk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  logic                 i_cmd_ready,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic                 i_res_found,
    input  fwrbv_pkg::t_port_val i_res_out_value,
    input  fwrbv_pkg::t_port_cnt i_res_count,
    input  fwrbv_pkg::t_port_val i_res_head_value
);

    logic       cmd_acc;
    logic       res_acc;
    logic [1:0] r_pend;

    assign cmd_acc = i_cmd_valid && i_cmd_ready;
    assign res_acc = i_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + {1'b0, cmd_acc} - {1'b0, res_acc};
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_found)
            && $stable(i_res_out_value) && $stable(i_res_count)
            && $stable(i_res_head_value)))
        else $error("result word changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (r_pend != 2'd0))
        else $error("result word without a pending command");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'd2)
        else $error("more than two commands in flight");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |=> !$rose(i_res_valid))
        else $error("result word too soon after command");

endmodule

bind fifo_with_remove_by_value fwrbv_chk u_fwrbv_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cmd_valid      (i_cmd.valid),
    .i_cmd_ready      (i_cmd.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_found      (o_res.found),
    .i_res_out_value  (o_res.out_value),
    .i_res_count      (o_res.count),
    .i_res_head_value (o_res.head_value)
);

`default_nettype wire
